[sv/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for the barometric compensation block
// Register indexes, status codes, compensation constants and the sideband
// record that rides through the pipelined dividers.
// ----------------------------------------------------------------------------
package bsc_pkg;

	// Divider width: one quotient bit per stage
	localparam int DIV_W = 32;

	// Configuration register indexes
	localparam logic [2:0] CFG_OSS    = 3'd0;
	localparam logic [2:0] CFG_OFFSET = 3'd1;
	localparam logic [2:0] CFG_SCALE  = 3'd2;
	localparam logic [2:0] CFG_SECOND = 3'd3;
	localparam logic [2:0] CFG_TEMP   = 3'd4;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RAW_ZERO = 2'd1;
	localparam logic [1:0] ST_DIV_ZERO = 2'd2;

	// Compensation constants
	localparam logic [31:0] T_SHIFT_OFFSET = 32'd4000;
	localparam logic [31:0] T_ROUND        = 32'd8;
	localparam logic [15:0] B7_SCALE       = 16'd50000;
	localparam logic [31:0] P_COEF_SQ      = 32'd3038;
	localparam logic [31:0] P_COEF_LIN     = 32'hFFFF_E343; // -7357
	localparam logic [31:0] P_COEF_OFS     = 32'd3791;
	localparam logic [31:0] X3_BIAS        = 32'd32768;
	localparam logic [31:0] ROUND_TWO      = 32'd2;
	localparam int          PRESSURE_MAX   = 262143;
	localparam int          TEMP_MAX       = 32767;
	localparam int          TEMP_MIN       = -32768;

	// Data that travels alongside a division
	typedef struct packed {
		logic signed [31:0] x1;
		logic               neg;
		logic [1:0]         status;
		logic [18:0]        up;
		logic signed [15:0] temp;
		logic               big;
	} side_t;

	// One finished result
	typedef struct packed {
		logic signed [15:0] temp;
		logic [17:0]        pres;
		logic [1:0]         status;
	} res_t;

endpackage

[sv/bsc_div.sv]
// ----------------------------------------------------------------------------
// bsc_div: pipelined unsigned restoring divider
// One quotient bit per stage, 32 stages, sideband record carried alongside.
// ----------------------------------------------------------------------------
module bsc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [31:0]         in_dividend,
	input  logic [31:0]         in_divisor,
	input  bsc_pkg::side_t      in_side,
	output logic                out_valid,
	output logic [31:0]         out_quotient,
	output bsc_pkg::side_t      out_side
);

	localparam int N = bsc_pkg::DIV_W;

	logic [N-1:0]   rem_s [N];
	logic [N-1:0]   dq_s  [N];
	logic [N-1:0]   dvs_s [N];
	bsc_pkg::side_t side_s [N];
	logic [N-1:0]   vld_s;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N-1:0]   src_rem;
		logic [N-1:0]   src_dq;
		logic [N-1:0]   src_dvs;
		bsc_pkg::side_t src_side;
		logic           src_vld;
		logic [N:0]     trial;
		logic [N:0]     diff;
		logic [N-1:0]   rem_d;
		logic           bit_d;

		// Select the previous stage or the input
		if (k == 0) begin : g_first
			assign src_rem  = '0;
			assign src_dq   = in_dividend;
			assign src_dvs  = in_divisor;
			assign src_side = in_side;
			assign src_vld  = in_valid;
		end else begin : g_next
			assign src_rem  = rem_s[k-1];
			assign src_dq   = dq_s[k-1];
			assign src_dvs  = dvs_s[k-1];
			assign src_side = side_s[k-1];
			assign src_vld  = vld_s[k-1];
		end

		// Shift in the next dividend bit and try to subtract
		always_comb begin
			trial = {src_rem, src_dq[N-1]};
			diff  = trial - {1'b0, src_dvs};
			if (trial >= {1'b0, src_dvs}) begin
				rem_d = diff[N-1:0];
				bit_d = 1'b1;
			end else begin
				rem_d = trial[N-1:0];
				bit_d = 1'b0;
			end
		end

		// Advance valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= src_vld;
			end
		end

		// Advance payload
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_d;
				dq_s[k]   <= {src_dq[N-2:0], bit_d};
				dvs_s[k]  <= src_dvs;
				side_s[k] <= src_side;
			end
		end
	end

	assign out_valid    = vld_s[N-1];
	assign out_quotient = dq_s[N-1];
	assign out_side     = side_s[N-1];

endmodule

[sv/barometric_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// barometric_sensor_compensation: temperature and pressure compensation
// Turns raw temperature and pressure readings into 0.1 degC and pascals.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_valid/cfg_ready (always ready) writes register
//   cfg_index with cfg_data; 0 oversampling, 1 AC1..AC3, 2 AC4..AC6,
//   3 B1/B2, 4 MC/MD. Write only while no reading is in flight.
//   Input: in_valid/in_ready transfers one raw_temperature/raw_pressure pair.
//   Output: out_valid/out_ready transfers temperature_tenths, pressure_pa
//   and status, one result per input pair, in order.
//   From input transfer to out_valid a reading passes three setup
//   stages, a 32-stage temperature divider, seven stages, a 32-stage
//   pressure divider, two stages and the output register.
//   Throughput is one pair per cycle unless a full output queue holds
//   the pipeline; the two one-bit-per-stage dividers set depth, not rate.
//   Reset clears all configuration registers and empties the pipeline.
//   The output holds a two-entry queue; when it is full and a result is
//   ready to enter it, the whole pipeline and in_ready hold until the
//   receiver takes a result.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        raw_temperature,
	input  logic [23:0]        raw_pressure,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] temperature_tenths,
	output logic [17:0]        pressure_pa,
	output logic [1:0]         status
);

	// Configuration registers
	logic [1:0]  oss_q;
	logic [47:0] offset_q;
	logic [47:0] scale_q;
	logic [31:0] second_q;
	logic [31:0] tcoef_q;

	assign cfg_ready = 1'b1;

	// Take a configuration transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q    <= '0;
			offset_q <= '0;
			scale_q  <= '0;
			second_q <= '0;
			tcoef_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bsc_pkg::CFG_OSS:    oss_q    <= cfg_data[1:0];
				bsc_pkg::CFG_OFFSET: offset_q <= cfg_data;
				bsc_pkg::CFG_SCALE:  scale_q  <= cfg_data;
				bsc_pkg::CFG_SECOND: second_q <= cfg_data[31:0];
				bsc_pkg::CFG_TEMP:   tcoef_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Calibration words, sign extended to 32 bits where signed
	logic [31:0] ac1e, ac2e, ac3e, ac4e, b1e, b2e, mce, mde;
	logic [15:0] ac5, ac6;

	assign ac1e = {{16{offset_q[47]}}, offset_q[47:32]};
	assign ac2e = {{16{offset_q[31]}}, offset_q[31:16]};
	assign ac3e = {{16{offset_q[15]}}, offset_q[15:0]};
	assign ac4e = {16'd0, scale_q[47:32]};
	assign ac5  = scale_q[31:16];
	assign ac6  = scale_q[15:0];
	assign b1e  = {{16{second_q[31]}}, second_q[31:16]};
	assign b2e  = {{16{second_q[15]}}, second_q[15:0]};
	assign mce  = {{16{tcoef_q[31]}}, tcoef_q[31:16]};
	assign mde  = {{16{tcoef_q[15]}}, tcoef_q[15:0]};

	// Pipeline advance and output queue
	bsc_pkg::res_t res_d;
	bsc_pkg::res_t ent_q [2];
	logic [1:0]    cnt_q;
	logic          adv, push, pop;
	logic          vld_s12;

	assign adv      = !(cnt_q == 2'd2 && vld_s12);
	assign in_ready = adv;
	assign push     = adv && vld_s12;
	assign pop      = out_valid && out_ready;

	// ---------------- Stage 1: capture and align the readings
	logic        vld_s1;
	logic [15:0] ut_s1;
	logic [18:0] up_s1;
	logic [23:0] up_sh;

	assign up_sh = raw_pressure >> (4'd8 - {2'b00, oss_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ut_s1 <= raw_temperature;
			up_s1 <= up_sh[18:0];
		end
	end

	// ---------------- Stage 2: X1 = (UT - AC6) * AC5 >> 15
	logic               vld_s2;
	logic signed [31:0] x1_s2;
	logic [1:0]         st_s2;
	logic [18:0]        up_s2;
	logic signed [16:0] tdiff;
	logic signed [33:0] tprod;

	assign tdiff = $signed({1'b0, ut_s1}) - $signed({1'b0, ac6});
	assign tprod = tdiff * $signed({1'b0, ac5});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s2 <= $signed(tprod[31:0]) >>> 15;
			st_s2 <= (ut_s1 == '0 || up_s1 == '0) ? bsc_pkg::ST_RAW_ZERO : bsc_pkg::ST_OK;
			up_s2 <= up_s1;
		end
	end

	// ---------------- Stage 3: temperature divisor X1 + MD
	logic        vld_s3;
	logic [31:0] x1_s3;
	logic [31:0] x2d_s3;
	logic [1:0]  st_s3;
	logic [18:0] up_s3;
	logic [31:0] x2d;

	assign x2d = x1_s2 + mde;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s3  <= x1_s2;
			x2d_s3 <= x2d;
			up_s3  <= up_s2;
			if (st_s2 == bsc_pkg::ST_OK && x2d == '0) begin
				st_s3 <= bsc_pkg::ST_DIV_ZERO;
			end else begin
				st_s3 <= st_s2;
			end
		end
	end

	// Temperature division MC * 2048 / (X1 + MD) on magnitudes
	logic [31:0]    mc_mag, x2_mag, diva_dvd, diva_dvs, diva_q;
	bsc_pkg::side_t diva_in_side, diva_out_side;
	logic           diva_vld;

	assign mc_mag   = mce[31] ? (~mce + 32'd1) : mce;
	assign x2_mag   = x2d_s3[31] ? (~x2d_s3 + 32'd1) : x2d_s3;
	assign diva_dvd = mc_mag << 11;
	assign diva_dvs = (x2_mag == '0) ? 32'd1 : x2_mag;

	always_comb begin
		diva_in_side        = '0;
		diva_in_side.x1     = $signed(x1_s3);
		diva_in_side.neg    = mce[31] ^ x2d_s3[31];
		diva_in_side.status = st_s3;
		diva_in_side.up     = up_s3;
	end

	bsc_div u_div_temp (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.in_valid     (vld_s3),
		.in_dividend  (diva_dvd),
		.in_divisor   (diva_dvs),
		.in_side      (diva_in_side),
		.out_valid    (diva_vld),
		.out_quotient (diva_q),
		.out_side     (diva_out_side)
	);

	// ---------------- Stage 4: B5, true temperature, B6
	logic               vld_s4;
	logic [31:0]        b6_s4;
	logic signed [15:0] temp_s4;
	logic [1:0]         st_s4;
	logic [18:0]        up_s4;
	logic [31:0]        qa, b5;
	logic signed [31:0] tr;
	logic signed [15:0] tsat;

	always_comb begin
		qa = diva_out_side.neg ? (~diva_q + 32'd1) : diva_q;
		b5 = diva_out_side.x1 + qa;
		tr = $signed(b5 + bsc_pkg::T_ROUND) >>> 4;
		if (tr > bsc_pkg::TEMP_MAX) begin
			tsat = 16'sh7FFF;
		end else if (tr < bsc_pkg::TEMP_MIN) begin
			tsat = 16'sh8000;
		end else begin
			tsat = tr[15:0];
		end
		if (diva_out_side.status != bsc_pkg::ST_OK) begin
			tsat = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= diva_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b6_s4   <= b5 - bsc_pkg::T_SHIFT_OFFSET;
			temp_s4 <= tsat;
			st_s4   <= diva_out_side.status;
			up_s4   <= diva_out_side.up;
		end
	end

	// ---------------- Stage 5: B6 squared, AC2 * B6, AC3 * B6
	logic               vld_s5;
	logic [31:0]        sqp_s5, p2_s5, p3_s5;
	logic signed [15:0] temp_s5;
	logic [1:0]         st_s5;
	logic [18:0]        up_s5;
	logic [63:0]        m_sq, m_ac2, m_ac3;

	assign m_sq  = b6_s4 * b6_s4;
	assign m_ac2 = ac2e * b6_s4;
	assign m_ac3 = ac3e * b6_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqp_s5  <= m_sq[31:0];
			p2_s5   <= m_ac2[31:0];
			p3_s5   <= m_ac3[31:0];
			temp_s5 <= temp_s4;
			st_s5   <= st_s4;
			up_s5   <= up_s4;
		end
	end

	// ---------------- Stage 6: B2 * SQ and B1 * SQ
	logic               vld_s6;
	logic [31:0]        mb2_s6, mb1_s6, x2a_s6, x1b_s6;
	logic signed [15:0] temp_s6;
	logic [1:0]         st_s6;
	logic [18:0]        up_s6;
	logic [31:0]        sq;
	logic [63:0]        m_b2, m_b1;

	assign sq   = $signed(sqp_s5) >>> 12;
	assign m_b2 = b2e * sq;
	assign m_b1 = b1e * sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mb2_s6  <= m_b2[31:0];
			mb1_s6  <= m_b1[31:0];
			x2a_s6  <= $signed(p2_s5) >>> 11;
			x1b_s6  <= $signed(p3_s5) >>> 13;
			temp_s6 <= temp_s5;
			st_s6   <= st_s5;
			up_s6   <= up_s5;
		end
	end

	// ---------------- Stage 7: B3 before rounding, X3 sum for B4
	logic               vld_s7;
	logic [31:0]        b3p_s7, sum_s7;
	logic signed [15:0] temp_s7;
	logic [1:0]         st_s7;
	logic [18:0]        up_s7;
	logic [31:0]        x3a, b3sum, x2b;

	assign x3a   = ($signed(mb2_s6) >>> 11) + $signed(x2a_s6);
	assign b3sum = (ac1e << 2) + x3a;
	assign x2b   = $signed(mb1_s6) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b3p_s7  <= b3sum << oss_q;
			sum_s7  <= x1b_s6 + x2b + bsc_pkg::ROUND_TWO;
			temp_s7 <= temp_s6;
			st_s7   <= st_s6;
			up_s7   <= up_s6;
		end
	end

	// ---------------- Stage 8: round B3, bias X3
	logic               vld_s8;
	logic [31:0]        b3_s8, v_s8;
	logic signed [15:0] temp_s8;
	logic [1:0]         st_s8;
	logic [18:0]        up_s8;
	logic [31:0]        b3r, x3b;

	assign b3r = $signed(b3p_s7 + bsc_pkg::ROUND_TWO) >>> 2;
	assign x3b = $signed(sum_s7) >>> 2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b3_s8   <= b3r;
			v_s8    <= x3b + bsc_pkg::X3_BIAS;
			temp_s8 <= temp_s7;
			st_s8   <= st_s7;
			up_s8   <= up_s7;
		end
	end

	// ---------------- Stage 9: B4 and UP - B3
	logic               vld_s9;
	logic [16:0]        b4_s9;
	logic [31:0]        b7a_s9;
	logic signed [15:0] temp_s9;
	logic [1:0]         st_s9;
	logic [63:0]        m_b4;

	assign m_b4 = ac4e * v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b4_s9   <= m_b4[31:15];
			b7a_s9  <= {13'd0, up_s8} - b3_s8;
			temp_s9 <= temp_s8;
			st_s9   <= st_s8;
		end
	end

	// ---------------- Stage 10: B7 and pressure divisor check
	logic               vld_s10;
	logic [16:0]        b4_s10;
	logic [31:0]        b7_s10;
	logic signed [15:0] temp_s10;
	logic [1:0]         st_s10;
	logic [15:0]        b7_scale;
	logic [47:0]        m_b7;

	assign b7_scale = bsc_pkg::B7_SCALE >> oss_q;
	assign m_b7     = b7a_s9 * b7_scale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b7_s10   <= m_b7[31:0];
			b4_s10   <= b4_s9;
			temp_s10 <= temp_s9;
			if (st_s9 == bsc_pkg::ST_OK && b4_s9 == '0) begin
				st_s10 <= bsc_pkg::ST_DIV_ZERO;
			end else begin
				st_s10 <= st_s9;
			end
		end
	end

	// Pressure division: 2 * B7 / B4, or B7 / B4 doubled when B7 has its top bit
	logic [31:0]    divb_dvd, divb_dvs, divb_q;
	bsc_pkg::side_t divb_in_side, divb_out_side;
	logic           divb_vld;

	assign divb_dvd = b7_s10[31] ? b7_s10 : {b7_s10[30:0], 1'b0};
	assign divb_dvs = (b4_s10 == '0) ? 32'd1 : {15'd0, b4_s10};

	always_comb begin
		divb_in_side        = '0;
		divb_in_side.status = st_s10;
		divb_in_side.temp   = temp_s10;
		divb_in_side.big    = b7_s10[31];
	end

	bsc_div u_div_pres (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.in_valid     (vld_s10),
		.in_dividend  (divb_dvd),
		.in_divisor   (divb_dvs),
		.in_side      (divb_in_side),
		.out_valid    (divb_vld),
		.out_quotient (divb_q),
		.out_side     (divb_out_side)
	);

	// ---------------- Stage 11: P, (P >> 8) squared, linear term
	logic               vld_s11;
	logic [31:0]        p_s11, sqq_s11, lin_s11;
	logic signed [15:0] temp_s11;
	logic [1:0]         st_s11;
	logic [31:0]        pu, px;
	logic [63:0]        m_pp, m_lin;

	assign pu    = divb_out_side.big ? {divb_q[30:0], 1'b0} : divb_q;
	assign px    = $signed(pu) >>> 8;
	assign m_pp  = px * px;
	assign m_lin = bsc_pkg::P_COEF_LIN * pu;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (adv) begin
			vld_s11 <= divb_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s11    <= pu;
			sqq_s11  <= m_pp[31:0];
			lin_s11  <= m_lin[31:0];
			temp_s11 <= divb_out_side.temp;
			st_s11   <= divb_out_side.status;
		end
	end

	// ---------------- Stage 12: quadratic term
	logic [31:0]        p_s12, m_s12, lin16_s12;
	logic signed [15:0] temp_s12;
	logic [1:0]         st_s12;
	logic [63:0]        m_quad;

	assign m_quad = sqq_s11 * bsc_pkg::P_COEF_SQ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (adv) begin
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s12     <= p_s11;
			m_s12     <= m_quad[31:0];
			lin16_s12 <= $signed(lin_s11) >>> 16;
			temp_s12  <= temp_s11;
			st_s12    <= st_s11;
		end
	end

	// Final correction and saturation
	logic [31:0]        x3p;
	logic signed [31:0] pf;

	always_comb begin
		x3p = ($signed(m_s12) >>> 16) + $signed(lin16_s12) +
			$signed(bsc_pkg::P_COEF_OFS);
		pf  = $signed(p_s12) + ($signed(x3p) >>> 4);
		res_d.temp   = temp_s12;
		res_d.status = st_s12;
		if (st_s12 != bsc_pkg::ST_OK || pf < 0) begin
			res_d.pres = '0;
		end else if (pf > bsc_pkg::PRESSURE_MAX) begin
			res_d.pres = '1;
		end else begin
			res_d.pres = pf[17:0];
		end
	end

	// ---------------- Output queue: two entries, head at entry 0
	logic widx;

	assign widx = 1'(cnt_q - {1'b0, pop});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	// Fill the free slot or shift the tail to the head
	always_ff @(posedge clk) begin
		if (push && widx == 1'b0) begin
			ent_q[0] <= res_d;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
		end
		if (push && widx == 1'b1) begin
			ent_q[1] <= res_d;
		end
	end

	assign out_valid          = (cnt_q != 2'd0);
	assign temperature_tenths = ent_q[0].temp;
	assign pressure_pa        = ent_q[0].pres;
	assign status             = ent_q[0].status;

`ifndef SYNTH
	// Queue never counts past two entries
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue count out of range");

	// Full queue with a waiting result holds the input side
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && vld_s12) |-> !in_ready)
		else $error("pipeline advanced into a full queue");

	// Zero raw reading clears both results
	a_raw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == bsc_pkg::ST_RAW_ZERO) |->
		(temperature_tenths == '0 && pressure_pa == '0))
		else $error("raw zero result carries data");

	// Any division fault clears the pressure
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == bsc_pkg::ST_DIV_ZERO) |-> pressure_pa == '0)
		else $error("division fault result carries pressure");

	// Status never takes the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == bsc_pkg::ST_OK || status == bsc_pkg::ST_RAW_ZERO ||
		status == bsc_pkg::ST_DIV_ZERO))
		else $error("unused status code");
`endif

endmodule
